/* rtl/block_average_error_estimator_core_macros.svh */
// Assertion macros used by the estimator core.
`ifndef BLOCK_AVERAGE_ERROR_ESTIMATOR_CORE_MACROS_SVH
`define BLOCK_AVERAGE_ERROR_ESTIMATOR_CORE_MACROS_SVH
// Checks that an implication holds on every clock edge outside reset.
`define BAEE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Checks that a condition holds on every clock edge outside reset.
`define BAEE_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`endif

/* rtl/baee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baee_pkg
// Shared constants and types of the block average error estimator.
// ----------------------------------------------------------------------------
package baee_pkg;
    localparam int CHANNELS      = 5;
    localparam int FRACTION_BITS = 16;
    localparam int CH_W          = 3;
    localparam int SAMPLE_W      = 32;
    localparam int SUM_W         = 48;
    localparam int SQ_W          = 64;
    localparam int CNT_W         = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [SQ_W-1:0]     sq_t;
    typedef logic        [CNT_W-1:0]    cnt_t;

    localparam sum_t S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Control from the sequencer to each lane.
    typedef struct packed {
        logic accumulate;
        logic clear_block;
    } lane_ctrl_t;

    // Result fields of one channel.
    typedef struct packed {
        logic signed [31:0] block_mean;
        logic signed [31:0] running_mean;
        logic        [31:0] standard_error;
    } result_t;

    // Saturating signed 48-bit add of a 32-bit sample or mean.
    function automatic sum_t sat_add48(input sum_t a, input logic signed [31:0] b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W-31){b[31]}}, b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? S48_MIN : S48_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            return -32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage

/* rtl/block_average_error_estimator_core.sv */
`timescale 1ns / 1ps
// A word that does not close a block is absorbed into the lane accumulators. Once a
// closing word is taken, the results are computed one channel at a time, each later
// one only after its predecessor is taken: four divisions, a square root and the
// running-sum update for each channel. Inside a block one sample word is taken per
// cycle; input and configuration are held off while the block end is merged. Reset
// clears sums and counts, length 100.
// ----------------------------------------------------------------------------
// block_average_error_estimator_core
// Block averaging with running mean and blocking standard error, five lanes.
// ----------------------------------------------------------------------------
module block_average_error_estimator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_temperature,
    input  logic signed [31:0] s_potential_energy,
    input  logic signed [31:0] s_kinetic_energy,
    input  logic signed [31:0] s_total_energy,
    input  logic signed [31:0] s_pressure,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_channel,
    output logic [15:0] m_block_number,
    output logic signed [31:0] m_block_mean,
    output logic signed [31:0] m_running_mean,
    output logic [31:0] m_standard_error,
    output logic        m_last
);
    import baee_pkg::*;
`include "block_average_error_estimator_core_macros.svh"

    cnt_t len_cfg_reg;
    cnt_t sample_count_reg;
    cnt_t block_count_reg;
    cnt_t len;
    logic accept, closing, busy;
    logic first_out;
    sample_t samples [CHANNELS];
    sum_t    sums    [CHANNELS];
    lane_ctrl_t ctrl;
    result_t res;

    assign samples[0] = s_temperature;
    assign samples[1] = s_potential_energy;
    assign samples[2] = s_kinetic_energy;
    assign samples[3] = s_total_energy;
    assign samples[4] = s_pressure;

    // A zero length behaves like one sample per block.
    assign len       = (len_cfg_reg == '0) ? 16'd1 : len_cfg_reg;
    // The merging stage reads the length while it works, so a new length is
    // only taken when it is idle.
    assign cfg_ready = !busy;
    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;
    assign closing   = ({1'b0, sample_count_reg} + 17'd1) >= {1'b0, len};
    assign ctrl.accumulate  = accept;
    assign ctrl.clear_block = closing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg      <= 16'd100;
            sample_count_reg <= '0;
            block_count_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                len_cfg_reg <= cfg_data;
            end
            if (accept) begin
                if (closing) begin
                    sample_count_reg <= '0;
                    if (block_count_reg != 16'hFFFF) begin
                        block_count_reg <= block_count_reg + 16'd1;
                    end
                end else begin
                    sample_count_reg <= sample_count_reg + 16'd1;
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            baee_lane u_lane (
                .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
                .sample(samples[g]), .block_sum(sums[g])
            );
        end
    endgenerate

    baee_merge u_merge (
        .aclk(aclk), .aresetn(aresetn), .start(accept && closing), .sums(sums),
        .len(len), .n(block_count_reg), .busy(busy), .res_valid(m_valid),
        .res_ready(m_ready), .res_channel(m_channel), .res(res), .res_last(m_last)
    );

    assign m_block_number   = block_count_reg;
    assign m_block_mean     = res.block_mean;
    assign m_running_mean   = res.running_mean;
    assign m_standard_error = res.standard_error;

    assign first_out = m_valid && (m_block_number == 16'd1);

    `BAEE_ASSERT_IMP(a_no_input_busy, aclk, aresetn, m_valid, !s_ready, "input while busy")
    `BAEE_ASSERT_IMP(a_ch_range, aclk, aresetn, m_valid, m_channel < 3'd5, "channel range")
    `BAEE_ASSERT_IMP(a_first_zero, aclk, aresetn, first_out, m_standard_error == '0, "first error")
endmodule

/* rtl/baee_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baee_lane
// One channel lane: saturating block accumulator.
// ----------------------------------------------------------------------------
module baee_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  baee_pkg::lane_ctrl_t ctrl,
    input  baee_pkg::sample_t   sample,
    output baee_pkg::sum_t      block_sum
);
    import baee_pkg::*;

    sum_t sum_reg;

    // The block sum including the current word; a closing word empties the
    // accumulator so that the next block starts from zero.
    assign block_sum = sat_add48(sum_reg, sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.accumulate) begin
            sum_reg <= ctrl.clear_block ? '0 : block_sum;
        end
    end
endmodule

/* rtl/baee_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baee_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module baee_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import baee_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted  = {r_reg, q_reg[63]};
    assign diff     = shifted - {1'b0, d_reg};
    assign quotient = q_reg;
    assign done     = busy_reg && (cnt_reg == 7'd63);

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b0;
        end else if (busy_reg) begin
            if (!diff[64]) begin
                r_next = diff[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = shifted[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
            end
        end
        if (start) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg <= divisor;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end
endmodule

/* rtl/baee_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baee_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module baee_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import baee_pkg::*;

    logic [63:0] x_reg;
    logic [31:0] r_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] trial;
    logic [63:0] trial_sq;

    // Build the root from the top bit down; one 32x32 square a cycle.
    assign trial    = r_reg | (32'h8000_0000 >> cnt_reg);
    assign trial_sq = {32'd0, trial} * {32'd0, trial};
    assign root     = r_reg;
    assign done     = busy_reg && (cnt_reg == 5'd31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == 5'd31) begin
            busy_reg <= 1'b0;
        end
        if (start) begin
            x_reg   <= radicand;
            r_reg   <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (trial_sq <= x_reg) begin
                r_reg <= trial;
            end
            cnt_reg <= cnt_reg + 5'd1;
        end
    end
endmodule

/* rtl/baee_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baee_merge
// Merging stage: walks the lanes' block sums one channel at a time and
// computes block mean, running mean and standard error with shared units.
// ----------------------------------------------------------------------------
module baee_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  baee_pkg::sum_t      sums [baee_pkg::CHANNELS],
    input  baee_pkg::cnt_t      len,
    input  baee_pkg::cnt_t      n,
    output logic                busy,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [2:0]          res_channel,
    output baee_pkg::result_t   res,
    output logic                res_last
);
    import baee_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIVM = 5'd1;
    localparam logic [4:0] S_WM   = 5'd2;
    localparam logic [4:0] S_CM   = 5'd3;
    localparam logic [4:0] S_ACC  = 5'd4;
    localparam logic [4:0] S_DIVR = 5'd5;
    localparam logic [4:0] S_WR   = 5'd6;
    localparam logic [4:0] S_CR   = 5'd7;
    localparam logic [4:0] S_DIVS = 5'd8;
    localparam logic [4:0] S_WS   = 5'd9;
    localparam logic [4:0] S_CS   = 5'd10;
    localparam logic [4:0] S_DIVV = 5'd11;
    localparam logic [4:0] S_WV   = 5'd12;
    localparam logic [4:0] S_CV   = 5'd13;
    localparam logic [4:0] S_SQ   = 5'd14;
    localparam logic [4:0] S_WQ   = 5'd15;
    localparam logic [4:0] S_CQ   = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0]  state_reg;
    logic [CH_W-1:0] ch_reg;
    sum_t        sums_reg [CHANNELS];
    sum_t        sbm_reg  [CHANNELS];
    sq_t         ssq_reg  [CHANNELS];
    logic signed [31:0] mean_reg, rm_reg;
    logic [31:0] se_reg;
    logic [63:0] ms_reg, var_reg;
    logic [63:0] rm2_reg;

    logic        div_start, div_done, sq_start, sq_done;
    logic [63:0] div_a, div_b, div_q;
    logic [31:0] sq_root;
    logic        neg_reg;
    sum_t        cur_sum;
    sum_t        cur_sbm;
    logic [63:0] mag;
    logic signed [63:0] sdiv;
    logic signed [31:0] sq_in;
    logic [31:0] sq_abs;
    logic [63:0] sq_prod;
    logic [63:0] msq;
    logic [64:0] ssq_add;
    sum_t        sbm_new;
    logic [63:0] lim;

    assign cur_sum = sums_reg[ch_reg];
    assign cur_sbm = sbm_reg[ch_reg];
    assign sdiv    = neg_reg ? -$signed(div_q) : $signed(div_q);
    // One squarer serves the block mean and, while the square sum is divided,
    // the running mean.
    assign sq_in   = (state_reg == S_DIVS) ? rm_reg : mean_reg;
    assign sq_abs  = sq_in[31] ? 32'(-sq_in) : 32'(sq_in);
    assign sq_prod = {32'd0, sq_abs} * {32'd0, sq_abs};
    assign msq     = sq_prod >> FRACTION_BITS;
    assign ssq_add = {1'b0, ssq_reg[ch_reg]} + {1'b0, msq};
    assign sbm_new = sat_add48(cur_sbm, mean_reg);
    assign lim     = 64'hFFFF_FFFF_FFFF_FFFF >> FRACTION_BITS;

    always_comb begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = 64'd1;
        sq_start  = 1'b0;
        mag       = '0;
        unique case (state_reg)
            S_DIVM: begin
                mag       = cur_sum[SUM_W-1] ? -64'(cur_sum) : 64'(cur_sum);
                div_start = 1'b1;
                div_a     = mag;
                div_b     = {48'd0, len};
            end
            S_DIVR: begin
                mag       = cur_sbm[SUM_W-1] ? -64'(cur_sbm) : 64'(cur_sbm);
                div_start = 1'b1;
                div_a     = mag;
                div_b     = {48'd0, n};
            end
            S_DIVS: begin
                div_start = 1'b1;
                div_a     = ssq_reg[ch_reg];
                div_b     = {48'd0, n};
            end
            S_DIVV: begin
                div_start = 1'b1;
                div_a     = (ms_reg > rm2_reg) ? ms_reg - rm2_reg : 64'd0;
                div_b     = {48'd0, n} - 64'd1;
            end
            S_SQ: begin
                sq_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    baee_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    baee_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(var_reg << FRACTION_BITS), .done(sq_done), .root(sq_root)
    );

    assign busy        = (state_reg != S_IDLE);
    assign res_valid   = (state_reg == S_OUT);
    assign res_channel = ch_reg;
    assign res_last    = (ch_reg == CH_W'(CHANNELS - 1));
    assign res.block_mean     = mean_reg;
    assign res.running_mean   = rm_reg;
    assign res.standard_error = se_reg;

    // Each unit's result sits in its output register the cycle after done,
    // so every wait state hands over to a capture state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sbm_reg[c] <= '0;
                ssq_reg[c] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        sums_reg  <= sums;
                        ch_reg    <= '0;
                        state_reg <= S_DIVM;
                    end
                end
                S_DIVM: begin
                    neg_reg   <= cur_sum[SUM_W-1];
                    state_reg <= S_WM;
                end
                S_WM: begin
                    if (div_done) begin
                        state_reg <= S_CM;
                    end
                end
                S_CM: begin
                    mean_reg  <= sat32(sdiv);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    sbm_reg[ch_reg] <= sbm_new;
                    ssq_reg[ch_reg] <= ssq_add[64] ? '1 : ssq_add[63:0];
                    neg_reg   <= sbm_new[SUM_W-1];
                    state_reg <= S_DIVR;
                end
                S_DIVR: begin
                    state_reg <= S_WR;
                end
                S_WR: begin
                    if (div_done) begin
                        state_reg <= S_CR;
                    end
                end
                S_CR: begin
                    rm_reg    <= sat32(sdiv);
                    state_reg <= S_DIVS;
                end
                S_DIVS: begin
                    rm2_reg   <= msq;
                    state_reg <= S_WS;
                end
                S_WS: begin
                    if (div_done) begin
                        state_reg <= S_CS;
                    end
                end
                S_CS: begin
                    ms_reg    <= div_q;
                    state_reg <= S_DIVV;
                end
                S_DIVV: begin
                    state_reg <= S_WV;
                end
                S_WV: begin
                    if (div_done) begin
                        state_reg <= S_CV;
                    end
                end
                S_CV: begin
                    var_reg   <= (div_q > lim) ? lim : div_q;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    state_reg <= S_WQ;
                end
                S_WQ: begin
                    if (sq_done) begin
                        state_reg <= S_CQ;
                    end
                end
                S_CQ: begin
                    se_reg    <= (n > 16'd1) ? sq_root : 32'd0;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) begin
                        if (res_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= S_DIVM;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* test/tb_block_average_error_estimator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average error estimator testbench
// Drives sample words into the estimator and predicts every per-channel block
// result (block mean, running mean, standard error) in a local model. It
// compares each result word field by field. Block lengths are varied,
// including zero, one, the reset length, the largest length, and a length
// lowered in the middle of a block.
// ----------------------------------------------------------------------------
module tb_block_average_error_estimator_core;
    import baee_pkg::*;

    typedef sample_t sample_set_t [CHANNELS];

    // One expected result word.
    typedef struct {
        logic [2:0]         channel;
        cnt_t               block_number;
        logic signed [31:0] block_mean;
        logic signed [31:0] running_mean;
        logic [31:0]        standard_error;
        logic               last;
    } block_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    sample_t     s_temperature;
    sample_t     s_potential_energy;
    sample_t     s_kinetic_energy;
    sample_t     s_total_energy;
    sample_t     s_pressure;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_channel;
    logic [15:0] m_block_number;
    logic signed [31:0] m_block_mean;
    logic signed [31:0] m_running_mean;
    logic [31:0] m_standard_error;
    logic        m_last;

    // Local copy of the block state, advanced on every accepted sample word.
    logic [15:0] blk_len;
    longint      blk_sum [CHANNELS];
    longint      mean_sum [CHANNELS];
    bit [63:0]   sq_mean_sum [CHANNELS];
    int          samples_in_block;
    int          blocks_done;

    block_result_t pending_results[$];
    int            errors;
    int            samples_sent;
    bit            quiet;
    int            ready_hold;

    block_average_error_estimator_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_temperature      (s_temperature),
        .s_potential_energy (s_potential_energy),
        .s_kinetic_energy   (s_kinetic_energy),
        .s_total_energy     (s_total_energy),
        .s_pressure         (s_pressure),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_channel          (m_channel),
        .m_block_number     (m_block_number),
        .m_block_mean       (m_block_mean),
        .m_running_mean     (m_running_mean),
        .m_standard_error   (m_standard_error),
        .m_last             (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Generous watchdog well above the slowest legal run.
    initial begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clip48(input longint v);
        if (v > 64'sh7FFFFFFFFFFF) begin
            return 64'sh7FFFFFFFFFFF;
        end
        if (v < -64'sh800000000000) begin
            return -64'sh800000000000;
        end
        return v;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sh7FFFFFFF) begin
            return 64'sh7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            return -64'sh80000000;
        end
        return v;
    endfunction

    // Square of a Q16.16 value, kept in Q16.16 and truncated.
    function automatic bit [63:0] square_q(input longint m);
        bit [63:0] a;
        a = (m < 0) ? -m : m;
        return (a * a) >> FRACTION_BITS;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Adds one sample set into the block sums and, when the block closes,
    // queues one expected result per channel.
    function automatic void absorb_sample(input sample_set_t v);
        int            c;
        int            len;
        longint        mean;
        longint        rm;
        bit [63:0]     sq;
        bit [63:0]     ms;
        bit [63:0]     rm2;
        bit [63:0]     variance;
        bit [63:0]     se;
        bit [63:0]     n;
        block_result_t r;
        len = (blk_len == 0) ? 1 : int'(blk_len);
        for (c = 0; c < CHANNELS; c++) blk_sum[c] = clip48(blk_sum[c] + longint'(v[c]));
        if (samples_in_block + 1 < len) begin
            samples_in_block++;
            return;
        end
        samples_in_block = 0;
        if (blocks_done < 65535) blocks_done++;
        n = 64'(blocks_done);
        for (c = 0; c < CHANNELS; c++) begin
            mean = clip32(blk_sum[c] / longint'(len));
            blk_sum[c] = 0;
            mean_sum[c] = clip48(mean_sum[c] + mean);
            sq = square_q(mean);
            if (sq_mean_sum[c] > 64'hFFFFFFFFFFFFFFFF - sq) begin
                sq_mean_sum[c] = 64'hFFFFFFFFFFFFFFFF;
            end else begin
                sq_mean_sum[c] = sq_mean_sum[c] + sq;
            end
            rm = clip32(mean_sum[c] / longint'(n));
            se = 0;
            if (n > 1) begin
                ms = sq_mean_sum[c] / n;
                rm2 = square_q(rm);
                // Rounding can push the variance below zero; that reads as zero.
                variance = (ms > rm2) ? (ms - rm2) / (n - 1) : 0;
                if (variance > (64'hFFFFFFFFFFFFFFFF >> FRACTION_BITS)) begin
                    variance = 64'hFFFFFFFFFFFFFFFF >> FRACTION_BITS;
                end
                se = int_sqrt(variance << FRACTION_BITS);
                if (se > 64'hFFFFFFFF) se = 64'hFFFFFFFF;
            end
            r.channel        = 3'(c);
            r.block_number   = n[15:0];
            r.block_mean     = mean[31:0];
            r.running_mean   = rm[31:0];
            r.standard_error = se[31:0];
            r.last           = (c == CHANNELS - 1);
            pending_results.push_back(r);
        end
    endfunction

    // Sends one sample word, with an occasional idle burst in front of it.
    task automatic send_sample(input sample_set_t v);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_temperature      <= v[0];
        s_potential_energy <= v[1];
        s_kinetic_energy   <= v[2];
        s_total_energy     <= v[3];
        s_pressure         <= v[4];
        do @(posedge aclk); while (!s_ready);
        absorb_sample(v);
        samples_sent++;
    endtask

    // Waits until every expected result has come, then lets the pipeline drain.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_length(input logic [15:0] len);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        blk_len = len;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Values clustered around a base (the most frequent pick) so that the error is
    // meaningful, with extremes and fully random words mixed in.
    function automatic sample_t pick_value(input sample_t base);
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return -32'sh80000000;
            2: return 0;
            3, 4, 5, 6: return base + sample_t'($urandom_range(0, 262143)) - 131072;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_set_t random_set(input sample_t base);
        sample_set_t v;
        int c;
        for (c = 0; c < CHANNELS; c++) v[c] = pick_value(base + (c << 20));
        return v;
    endfunction

    function automatic sample_set_t flat_set(input sample_t x);
        sample_set_t v;
        int c;
        for (c = 0; c < CHANNELS; c++) v[c] = x;
        return v;
    endfunction

    // The length left by reset closes a block after one hundred words.
    task automatic test_default_length();
        sample_t base;
        int i;
        base = $urandom;
        for (i = 0; i < 100; i++) send_sample(random_set(base));
    endtask

    task automatic test_field_extremes();
        sample_set_t v;
        write_length(16'd1);
        send_sample(flat_set(32'sh7FFFFFFF));
        send_sample(flat_set(-32'sh80000000));
        send_sample(flat_set(0));
        v[0] = 32'sh7FFFFFFF; v[1] = -32'sh80000000; v[2] = -1; v[3] = 1;
        v[4] = 32'sh00010000;
        send_sample(v);
        send_sample(flat_set(-1));
        write_length(16'd2);
        send_sample(flat_set(32'sh7FFFFFFF));
        send_sample(flat_set(32'sh7FFFFFFF));
        send_sample(flat_set(-32'sh80000000));
        send_sample(flat_set(-32'sh80000000));
    endtask

    // A zero length behaves as a length of one.
    task automatic test_zero_length();
        write_length(16'd0);
        send_sample(flat_set(32'sh00030000));
        send_sample(flat_set(-32'sh00050000));
        send_sample(random_set($urandom));
    endtask

    // The largest length, then lowered in the middle of the block so that the
    // next word closes it.
    task automatic test_length_lowered();
        write_length(16'hFFFF);
        send_sample(flat_set(32'sh7FFFFFFF));
        send_sample(flat_set(32'sh7FFFFFFF));
        send_sample(flat_set(32'sh12345678));
        write_length(16'd2);
        send_sample(flat_set(-32'sh00001000));
    endtask

    task automatic test_random_blocks();
        logic [15:0] len;
        sample_t     base;
        int          words;
        int          i;
        while (samples_sent < 470) begin
            case ($urandom_range(0, 9))
                0: len = 16'd0;
                1: len = 16'($urandom_range(9, 20));
                default: len = 16'($urandom_range(1, 8));
            endcase
            write_length(len);
            // The final stretch runs with no idling on either side.
            quiet = (samples_sent > 420);
            base = $urandom;
            words = ((len == 0) ? 1 : int'(len)) * int'($urandom_range(1, 4));
            // Now and then leave a partial block to carry into the next length.
            if ($urandom_range(0, 4) == 0) words += int'($urandom_range(1, 3));
            for (i = 0; i < words; i++) send_sample(random_set(base));
        end
    endtask

    // Result side backpressure: alternating bursts of ready and stall.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_hold <= $urandom_range(1, 17);
            m_ready    <= quiet ? 1'b1 : 1'($urandom_range(0, 1));
        end
    end

    // Each accepted result word is checked against the oldest expectation.
    always @(posedge aclk) begin
        block_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected, channel %0d", $time,
                    m_channel);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_channel !== e.channel) begin
                    $display("%0t: channel expected %0d actual %0d", $time, e.channel,
                        m_channel);
                    errors++;
                end
                if (m_block_number !== e.block_number) begin
                    $display("%0t: block_number expected %0d actual %0d", $time,
                        e.block_number, m_block_number);
                    errors++;
                end
                if (m_block_mean !== e.block_mean) begin
                    $display("%0t: block_mean expected %h actual %h", $time,
                        e.block_mean, m_block_mean);
                    errors++;
                end
                if (m_running_mean !== e.running_mean) begin
                    $display("%0t: running_mean expected %h actual %h", $time,
                        e.running_mean, m_running_mean);
                    errors++;
                end
                if (m_standard_error !== e.standard_error) begin
                    $display("%0t: standard_error expected %h actual %h", $time,
                        e.standard_error, m_standard_error);
                    errors++;
                end
                if (m_last !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int c;
        errors = 0;
        samples_sent = 0;
        quiet = 1'b0;
        ready_hold = 0;
        blk_len = 16'd100;
        samples_in_block = 0;
        blocks_done = 0;
        for (c = 0; c < CHANNELS; c++) begin
            blk_sum[c] = 0;
            mean_sum[c] = 0;
            sq_mean_sum[c] = 0;
        end
        aresetn            <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_data           <= '0;
        s_valid            <= 1'b0;
        s_temperature      <= '0;
        s_potential_energy <= '0;
        s_kinetic_energy   <= '0;
        s_total_energy     <= '0;
        s_pressure         <= '0;
        m_ready            <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_length();
        test_field_extremes();
        test_zero_length();
        test_length_lowered();
        test_random_blocks();
        wait_drained();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
